### rtl/assert_macros.svh
// Assertion macros used by the list store top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BOLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define BOLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

### rtl/bols_pkg.sv
// Package: operation, status and cell control codes and field widths for the list store.
package bols_pkg;

    // Operation codes carried by an input item
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;
    localparam logic [2:0] OP_SEARCH     = 3'd5;

    // Status codes returned with each result item
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_EMPTY     = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_BADPOS    = 3'd3;
    localparam logic [2:0] STS_NOTFOUND  = 3'd4;

    // Field widths
    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int STS_W   = 3;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 5;

    // Cell next-value selects
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LEFT  = 2'd1;
    localparam logic [1:0] CELL_RIGHT = 2'd2;
    localparam logic [1:0] CELL_LOAD  = 2'd3;

    typedef logic [DATA_W-1:0] t_data;

    // Control handed to each cell of the chain
    typedef struct packed {
        logic [1:0] sel;
        t_data      value;
    } t_cell_ctrl;

endpackage

### rtl/bols_cell.sv
// One storage cell of the element chain: holds one value, shifts, compares.
module bols_cell (
    input  logic                i_clk,
    input  bols_pkg::t_cell_ctrl i_ctrl,
    input  bols_pkg::t_data     i_left,
    input  bols_pkg::t_data     i_right,
    input  bols_pkg::t_data     i_key,
    output bols_pkg::t_data     o_data,
    output logic                o_match
);

    bols_pkg::t_data r_data;
    bols_pkg::t_data n_data;

    // Pick the next value: hold, take a neighbor's, or load a new element
    always_comb begin
        case (i_ctrl.sel)
            bols_pkg::CELL_HOLD:  n_data = r_data;
            bols_pkg::CELL_LEFT:  n_data = i_left;
            bols_pkg::CELL_RIGHT: n_data = i_right;
            bols_pkg::CELL_LOAD:  n_data = i_ctrl.value;
            default:              n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

### rtl/bols_find.sv
// Registered priority tree that finds the lowest set match flag.
module bols_find #(
    parameter int CAPACITY = 16,
    parameter int LVLS     = $clog2(CAPACITY),
    parameter int LEAVES   = 1 << LVLS
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [CAPACITY-1:0] i_match,
    output logic                o_hit,
    output logic [LVLS-1:0]     o_index
);

    logic [LEAVES-1:0] r_leaf;
    logic [LEAVES-2:0] r_node_hit;
    logic [LVLS-1:0]   r_node_idx [LEAVES-1];

    // Capture the match flags of a search; unused leaves never hit
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_leaf <= LEAVES'(i_match);
        end
    end

    // Each node keeps the lower-indexed hit of its two children
    for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
        logic            w_lhit;
        logic            w_rhit;
        logic [LVLS-1:0] w_lidx;
        logic [LVLS-1:0] w_ridx;

        if (2 * k + 1 >= LEAVES - 1) begin : g_lleaf
            assign w_lhit = r_leaf[2 * k + 1 - (LEAVES - 1)];
            assign w_lidx = LVLS'(2 * k + 1 - (LEAVES - 1));
        end else begin : g_lnode
            assign w_lhit = r_node_hit[2 * k + 1];
            assign w_lidx = r_node_idx[2 * k + 1];
        end

        if (2 * k + 2 >= LEAVES - 1) begin : g_rleaf
            assign w_rhit = r_leaf[2 * k + 2 - (LEAVES - 1)];
            assign w_ridx = LVLS'(2 * k + 2 - (LEAVES - 1));
        end else begin : g_rnode
            assign w_rhit = r_node_hit[2 * k + 2];
            assign w_ridx = r_node_idx[2 * k + 2];
        end

        always_ff @(posedge i_clk) begin
            r_node_hit[k] <= w_lhit | w_rhit;
            r_node_idx[k] <= w_lhit ? w_lidx : w_ridx;
        end
    end

    assign o_hit   = r_node_hit[0];
    assign o_index = r_node_idx[0];

endmodule

### rtl/bounded_ordered_list_store.sv
// Top level: ordered list store built from a chain of element cells.
//
//  Channel   Direction  Handshake        Payload (low bit first)
//  s_axis    in         tvalid / tready  operation[2:0], value[34:3], position[39:35]
//  m_axis    out        tvalid / tready  status[2:0], found_index[7:3], count[12:8]
//
// Push, pop, insert and unused codes need no wait state: the cells shift in place.
// A search runs through the leaf register and each registered level of the match
// tree, then waits for a free output register; no item is accepted while it runs.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
// A result waits in the output register; the next item is accepted in the cycle
// that register is taken, and input stalls while it is held.
module bounded_ordered_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // operation[2:0], value[34:3], position[39:35]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // status[2:0], found_index[7:3], count[12:8], 0
);

    `include "assert_macros.svh"

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LVLS = $clog2(CAPACITY);
    localparam int AW   = (CW > bols_pkg::POS_W) ? CW : bols_pkg::POS_W;
    localparam int WW   = $clog2(LVLS + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    // Input fields
    logic [bols_pkg::OP_W-1:0]  w_op;
    bols_pkg::t_data            w_value;
    logic [bols_pkg::POS_W-1:0] w_pos;

    assign w_op    = i_s_axis_tdata[2:0];
    assign w_value = i_s_axis_tdata[34:3];
    assign w_pos   = i_s_axis_tdata[39:35];

    // Control state
    logic                      r_state;
    logic [WW-1:0]             r_wait;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic [bols_pkg::STS_W-1:0] r_out_status;
    logic [bols_pkg::IDX_W-1:0] r_out_found;
    logic [bols_pkg::CNT_W-1:0] r_out_count;

    logic w_out_free;
    logic w_acc;
    logic w_search_acc;
    logic w_search_done;
    logic w_full;
    logic w_empty;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_search_acc    = w_acc && (w_op == bols_pkg::OP_SEARCH);
    assign w_search_done   = (r_state == ST_SEARCH) && (r_wait == '0) && w_out_free;
    assign w_full          = (r_count == CW'(CAPACITY));
    assign w_empty         = (r_count == '0);

    // Decode the operation into an insert or remove point
    logic                       w_ins;
    logic                       w_rem;
    logic [AW-1:0]              w_at;
    logic [bols_pkg::STS_W-1:0] w_status;

    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_at     = '0;
        w_status = bols_pkg::STS_OK;
        case (w_op)
            bols_pkg::OP_PUSH_FRONT: begin
                if (w_full) w_status = bols_pkg::STS_FULL;
                else        w_ins    = 1'b1;
            end
            bols_pkg::OP_PUSH_BACK: begin
                w_at = AW'(r_count);
                if (w_full) w_status = bols_pkg::STS_FULL;
                else        w_ins    = 1'b1;
            end
            bols_pkg::OP_POP_FRONT: begin
                if (w_empty) w_status = bols_pkg::STS_EMPTY;
                else         w_rem    = 1'b1;
            end
            bols_pkg::OP_POP_BACK: begin
                w_at = AW'(r_count) - AW'(1);
                if (w_empty) w_status = bols_pkg::STS_EMPTY;
                else         w_rem    = 1'b1;
            end
            bols_pkg::OP_INSERT: begin
                w_at = AW'(w_pos);
                if (w_full)                         w_status = bols_pkg::STS_FULL;
                else if (AW'(w_pos) > AW'(r_count)) w_status = bols_pkg::STS_BADPOS;
                else                                w_ins    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next count after an accepted item
    always_comb begin
        n_count = r_count;
        if (w_acc && w_ins)      n_count = r_count + CW'(1);
        else if (w_acc && w_rem) n_count = r_count - CW'(1);
    end

    // Cell chain: each cell loads, shifts from a neighbor or holds
    bols_pkg::t_cell_ctrl w_ctrl [CAPACITY];
    bols_pkg::t_data      w_data [CAPACITY];
    logic [CAPACITY-1:0]  w_cell_match;
    logic [CAPACITY-1:0]  w_match;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctrl[i].value = w_value;
            w_ctrl[i].sel   = bols_pkg::CELL_HOLD;
            if (w_acc && w_ins) begin
                if (AW'(i) == w_at)     w_ctrl[i].sel = bols_pkg::CELL_LOAD;
                else if (AW'(i) > w_at) w_ctrl[i].sel = bols_pkg::CELL_LEFT;
            end else if (w_acc && w_rem) begin
                if (AW'(i) >= w_at)     w_ctrl[i].sel = bols_pkg::CELL_RIGHT;
            end
            w_match[i] = w_cell_match[i] && (AW'(i) < AW'(r_count));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bols_pkg::t_data w_left;
        bols_pkg::t_data w_right;

        assign w_left  = (g == 0) ? w_data[g] : w_data[(g == 0) ? 0 : g - 1];
        assign w_right = (g == CAPACITY - 1) ? w_data[g]
                                             : w_data[(g == CAPACITY - 1) ? g : g + 1];

        bols_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (w_value),
            .o_data  (w_data[g]),
            .o_match (w_cell_match[g])
        );
    end

    // Lowest matching cell, found over the registered tree
    logic            w_hit;
    logic [LVLS-1:0] w_hit_idx;
    logic [LVLS:0]   w_found_full;

    bols_find #(
        .CAPACITY (CAPACITY)
    ) u_find (
        .i_clk   (i_clk),
        .i_load  (w_search_acc),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_index (w_hit_idx)
    );

    assign w_found_full = {1'b0, w_hit_idx} + (LVLS + 1)'(1);

    // Sequence a search and hold the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            case (r_state)
                ST_IDLE: begin
                    if (w_search_acc) begin
                        r_state <= ST_SEARCH;
                        r_wait  <= WW'(LVLS);
                    end
                end
                ST_SEARCH: begin
                    if (r_wait != '0)  r_wait  <= r_wait - WW'(1);
                    else if (w_out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_acc && !w_search_acc) || w_search_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_search_acc) begin
            r_out_status <= w_status;
            r_out_found  <= '0;
            r_out_count  <= bols_pkg::CNT_W'(n_count);
        end else if (w_search_done) begin
            r_out_status <= w_hit ? bols_pkg::STS_OK : bols_pkg::STS_NOTFOUND;
            r_out_found  <= w_hit ? bols_pkg::IDX_W'(w_found_full) : '0;
            r_out_count  <= bols_pkg::CNT_W'(r_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_count, r_out_found, r_out_status};

    `BOLS_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "count beyond capacity")
    `BOLS_ASSERT(a_search_stall, (r_state == ST_SEARCH) |-> !o_s_axis_tready,
        "item accepted during search")
    `BOLS_ASSERT(a_push_grows, (w_acc && (w_op == bols_pkg::OP_PUSH_BACK) && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)), "push did not grow the list")
    `BOLS_ASSERT(a_search_result, w_search_done |=> o_m_axis_tvalid,
        "search finished without a result")
    `BOLS_ASSERT(a_search_keeps, (r_state == ST_SEARCH) |=> $stable(r_count),
        "count changed during search")

endmodule
